// ===== rtl/core/hours_between_dates_top_macros.svh =====
// Assertion macros for the hours_between_dates block.
// Each macro takes a label, an antecedent, a consequent and a message string.
`ifndef HOURS_BETWEEN_DATES_TOP_MACROS_SVH
`define HOURS_BETWEEN_DATES_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during rst.
`define HBD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off during rst.
`define HBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hbd_pkg.sv =====
`default_nettype none

package hbd_pkg;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] DAYS_LONG  = 5'd31;
  localparam logic [4:0] DAYS_SHORT = 5'd30;
  localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
  localparam logic [4:0] DAYS_FEB = 5'd28;

  // 25 * INV25 == 1 modulo 2**14. A 14-bit year is a multiple of 25 exactly
  // when year * INV25 (mod 2**14) does not exceed (2**14 - 1) / 25.
  localparam logic [13:0] INV25     = 14'd7209;
  localparam logic [13:0] DIV25_MAX = 14'd655;

  typedef struct packed {
    logic load;   // capture a new input beat
    logic step;   // add the current month and advance one month
    logic store;  // write the finished result into the output register
  } hbd_cmd_t;

  typedef struct packed {
    logic done;   // the walk has reached the end month
    logic err;    // year gap or month order is out of range
  } hbd_sts_t;

  // Leap years follow the 400/100/4 rule; 100 and 400 are tested as
  // divisibility by 25 together with divisibility by 4 and 16.
  function automatic logic leap_year(input logic [13:0] year);
    logic [13:0] prod;
    logic        div25;
    prod  = year * INV25;
    div25 = (prod <= DIV25_MAX);
    return (year[1:0] == 2'd0) && (!div25 || (year[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month) inside
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
      MONTH_FEB: len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
      default: len = DAYS_LONG;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] clamp_month(input logic [3:0] month);
    logic [3:0] m;
    if (month < MONTH_JAN) begin
      m = MONTH_JAN;
    end else if (month > MONTH_DEC) begin
      m = MONTH_DEC;
    end else begin
      m = month;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hbd_datapath.sv =====
`default_nettype none

module hbd_datapath (
  input  wire logic             clk,
  input  wire hbd_pkg::hbd_cmd_t cmd,
  output hbd_pkg::hbd_sts_t     sts,
  input  wire logic [13:0]      from_year,
  input  wire logic [3:0]       from_month,
  input  wire logic [4:0]       from_day,
  input  wire logic [4:0]       from_hour,
  input  wire logic [13:0]      to_year,
  input  wire logic [3:0]       to_month,
  input  wire logic [4:0]       to_day,
  input  wire logic [4:0]       to_hour,
  output logic      [14:0]      hours,
  output logic                  range_error
);
  import hbd_pkg::*;

  logic [3:0]  month;
  logic [13:0] year;
  logic [3:0]  end_month;
  logic [13:0] end_year;
  logic [4:0]  start_day;
  logic [4:0]  end_day;
  logic [4:0]  start_hour;
  logic [4:0]  end_hour;
  logic [9:0]  days;
  logic        err;

  logic [3:0]  from_month_c;
  logic [3:0]  to_month_c;
  logic [14:0] year_after;
  logic        err_in;
  logic [4:0]  cur_len;
  logic signed [10:0] day_total;
  logic signed [15:0] day_ext;
  logic signed [15:0] total;
  logic        fail;

  assign from_month_c = clamp_month(from_month);
  assign to_month_c   = clamp_month(to_month);
  assign year_after   = {1'b0, from_year} + 15'd1;

  always_comb begin
    if (to_year == from_year) begin
      err_in = (to_month_c < from_month_c);
    end else begin
      err_in = ({1'b0, to_year} != year_after);
    end
  end

  assign cur_len = month_len(month, leap_year(year));

  assign sts.done = (month == end_month) && (year == end_year);
  assign sts.err  = err;

  // Hours = (walked month days + end day - start day) * 24 + end hour - start hour.
  assign day_total = $signed({1'b0, days}) + $signed({6'b0, end_day})
                   - $signed({6'b0, start_day});
  assign day_ext   = {{5{day_total[10]}}, day_total};
  assign total     = (day_ext <<< 4) + (day_ext <<< 3)
                   + $signed({11'b0, end_hour}) - $signed({11'b0, start_hour});
  assign fail      = err || total[15];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      month      <= from_month_c;
      year       <= from_year;
      end_month  <= to_month_c;
      end_year   <= to_year;
      start_day  <= from_day;
      end_day    <= to_day;
      start_hour <= from_hour;
      end_hour   <= to_hour;
      days       <= 10'd0;
      err        <= err_in;
    end else if (cmd.step) begin
      days <= days + {5'b0, cur_len};
      if (month >= MONTH_DEC) begin
        month <= MONTH_JAN;
        year  <= year + 14'd1;
      end else begin
        month <= month + 4'd1;
      end
    end
    if (cmd.store) begin
      hours       <= fail ? 15'd0 : total[14:0];
      range_error <= fail;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hbd_ctrl.sv =====
`default_nettype none

module hbd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hbd_pkg::hbd_cmd_t      cmd,
  input  wire hbd_pkg::hbd_sts_t sts
);
  import hbd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts.err || sts.done) begin
          state_next = ST_FIN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.store  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.store) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hours_between_dates_top.sv =====
// Sequence: an accepted input beat is loaded, then the month walk steps over the n
// whole months between the dates (0 to 23), adding one month length per cycle
// through a single adder; a rejected date pair skips the walk. The finish state then
// stores the result once the output register is free, and the controller returns
// to idle, so a new input beat is taken only after the previous result is stored.
// Reset: rst is synchronous and active high; it returns the controller to idle and
// drops out_valid. The datapath registers carry no reset.
`default_nettype none

module hours_between_dates_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [13:0] from_year,
  input  wire logic [3:0]  from_month,
  input  wire logic [4:0]  from_day,
  input  wire logic [4:0]  from_hour,
  input  wire logic [13:0] to_year,
  input  wire logic [3:0]  to_month,
  input  wire logic [4:0]  to_day,
  input  wire logic [4:0]  to_hour,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [14:0]      hours,
  output logic             range_error
);
  import hbd_pkg::*;

  // The controller sequences one date pair at a time. On an input beat the
  // datapath captures both dates, clamps the months into January..December and
  // decides at once whether the pair is out of range (year gap other than zero
  // or one, or an end month before the start month within one year).
  hbd_cmd_t cmd;
  hbd_sts_t sts;

  hbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath then walks from the start month to the end month, adding one
  // Gregorian month length per cycle and wrapping from December into January
  // of the next year so that February is judged on the right year. When the
  // walk ends, the hour total is formed with shifts and adds; a negative total
  // also counts as a range error, and an error result carries zero hours.
  // The result lands in an output register, so a finished beat may wait for
  // out_ready while the block already takes the next input beat.
  hbd_datapath u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .from_year   (from_year),
    .from_month  (from_month),
    .from_day    (from_day),
    .from_hour   (from_hour),
    .to_year     (to_year),
    .to_month    (to_month),
    .to_day      (to_day),
    .to_hour     (to_hour),
    .hours       (hours),
    .range_error (range_error)
  );

endmodule

`default_nettype wire

// ===== rtl/core/hbd_checker.sv =====
`default_nettype none

`include "hours_between_dates_top_macros.svh"

module hbd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [14:0] hours,
  input wire logic        range_error
);

  `HBD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(hours) && $stable(range_error),
    "output beat changed while stalled")
  `HBD_ASSERT_SAME(a_err_zero, out_valid && range_error, hours == 15'd0,
    "error beat carries nonzero hours")
  `HBD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
    "input taken while an item is in work")
  `HBD_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid),
    "result appeared one cycle after accept")

endmodule

bind hours_between_dates_top hbd_checker u_hbd_checker (.*);

`default_nettype wire
